FILE: src/bilp_pkg.sv
// Shared types, constants and codes for the bracketed integer list parser.
package bilp_pkg;

    localparam int VALUE_BITS = 32;
    localparam int DEPTH_BITS = 16;
    localparam int TOTAL_BITS = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_END   = 1'b1;
    localparam logic KIND_NUM = 1'b0;
    localparam logic KIND_SUM = 1'b1;

    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [VALUE_BITS-1:0] MAG_CAP = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] POS_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
    } t_in_item;

    typedef struct packed {
        logic                         kind;
        logic signed [VALUE_BITS-1:0] number;
        logic [TOTAL_BITS-1:0]        total;
        logic                         format_valid;
        logic                         halted;
        logic                         final_res;
    } t_out_item;

    // Classified byte as it travels from the front end to the executor
    typedef struct packed {
        logic       is_end;
        logic       ws;
        logic       digit;
        logic [3:0] dval;
        logic       open;
        logic       close;
        logic       comma;
        logic       sign;
        logic       minus;
    } t_cls;

endpackage

FILE: src/bilp_front.sv
// Front end: accepts input transactions and classifies each byte.
module bilp_front (
    input  logic              i_valid,
    input  bilp_pkg::t_in_item i_item,
    input  logic              i_full,
    output logic              o_stall,
    output logic              o_push,
    output bilp_pkg::t_cls    o_cls
);
    import bilp_pkg::*;

    logic [7:0] ch;

    assign ch      = i_item.ch;
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cls        = '0;
        o_cls.is_end = (i_item.op == OP_END);
        if (i_item.op == OP_BYTE) begin
            o_cls.ws    = ch inside {CH_SPACE, [CH_TAB:CH_CR]};
            o_cls.digit = ch inside {[CH_ZERO:CH_NINE]};
            o_cls.dval  = 4'(ch - CH_ZERO);
            o_cls.open  = (ch == CH_OPEN);
            o_cls.close = (ch == CH_CLOSE);
            o_cls.comma = (ch == CH_COMMA);
            o_cls.sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
            o_cls.minus = (ch == CH_MINUS);
        end
    end

endmodule

FILE: src/bilp_fifo.sv
// Short queue of classified bytes between the front end and the executor.
module bilp_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bilp_pkg::t_cls i_wdata,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_nempty,
    output bilp_pkg::t_cls o_rdata
);
    import bilp_pkg::*;

    t_cls               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr, n_wr;
    logic [FIFO_AW-1:0] r_rd, n_rd;
    logic [FIFO_AW:0]   r_cnt, n_cnt;
    logic               pop_ok;

    assign o_full   = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_rdata  = r_mem[r_rd];
    assign pop_ok   = i_pop && o_nempty;

    always_comb begin
        n_wr  = i_push ? FIFO_AW'(r_wr + 1'b1) : r_wr;
        n_rd  = pop_ok ? FIFO_AW'(r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt + (FIFO_AW+1)'(i_push) - (FIFO_AW+1)'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

FILE: src/bilp_exec.sv
// Executor: token state machine, bracket tracking and the output register.
module bilp_exec (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_head_valid,
    input  bilp_pkg::t_cls      i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output bilp_pkg::t_out_item o_item
);
    import bilp_pkg::*;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_SIGN,
        PH_DIGITS,
        PH_TAIL
    } t_phase;

    t_phase                r_phase, n_phase;
    logic                  r_neg, n_neg;
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic                  r_halt, n_halt;
    logic [TOTAL_BITS-1:0] r_emitted, n_emitted;
    logic                  r_seen, n_seen;
    logic                  r_first_open, n_first_open;
    logic                  r_last_close, n_last_close;
    logic [DEPTH_BITS-1:0] r_depth, n_depth;
    logic                  r_depth_err, n_depth_err;
    logic                  r_out_valid;
    t_out_item             r_out, n_res;

    t_cls                  cls;
    logic                  load_ok, do_load, go, need_out, has_token;
    logic [VALUE_BITS+3:0] mag_ext, mag10;
    logic [VALUE_BITS-1:0] mag_acc, sat_num;
    logic [TOTAL_BITS-1:0] emitted_inc;
    logic                  fmt_ok;

    assign cls       = i_head;
    assign load_ok   = !r_out_valid || !i_stall;
    assign has_token = (r_phase == PH_DIGITS) || (r_phase == PH_TAIL);

    // magnitude * 10 + digit, clamped at the cap
    always_comb begin
        mag_ext = {4'b0000, r_mag};
        mag10   = (mag_ext << 3) + (mag_ext << 1) + {{VALUE_BITS{1'b0}}, cls.dval};
        mag_acc = (mag10 > {4'b0000, MAG_CAP}) ? MAG_CAP : mag10[VALUE_BITS-1:0];
    end

    // magnitude never exceeds the cap, so its top bit flags the cap exactly
    assign sat_num     = r_neg ? (~r_mag + 1'b1) : (r_mag[VALUE_BITS-1] ? POS_MAX : r_mag);
    assign emitted_inc = (r_emitted == '1) ? r_emitted : r_emitted + 1'b1;
    assign fmt_ok      = r_seen && r_first_open && r_last_close && !r_depth_err
                         && (r_depth == '0);

    always_comb begin
        n_phase      = r_phase;
        n_neg        = r_neg;
        n_mag        = r_mag;
        n_halt       = r_halt;
        n_emitted    = r_emitted;
        n_seen       = r_seen;
        n_first_open = r_first_open;
        n_last_close = r_last_close;
        n_depth      = r_depth;
        n_depth_err  = r_depth_err;
        n_res        = '0;
        need_out     = 1'b0;
        o_pop        = 1'b0;
        do_load      = 1'b0;
        go           = 1'b0;

        n_res.kind         = KIND_NUM;
        n_res.number       = sat_num;
        n_res.total        = emitted_inc;
        n_res.format_valid = 1'b0;
        n_res.halted       = r_halt;
        n_res.final_res    = 1'b1;

        if (i_head_valid && cls.is_end) begin
            go = load_ok;
            if (!r_halt && has_token) begin
                // pending number goes out first; the end transaction stays queued
                n_res.final_res = 1'b0;
                n_emitted       = emitted_inc;
                n_phase         = PH_LEAD;
                n_neg           = 1'b0;
                n_mag           = '0;
                do_load         = load_ok;
            end else begin
                n_res.kind         = KIND_SUM;
                n_res.number       = '0;
                n_res.total        = r_emitted;
                n_res.format_valid = fmt_ok;
                n_res.halted       = r_halt || (r_phase == PH_SIGN);
                n_phase            = PH_LEAD;
                n_neg              = 1'b0;
                n_mag              = '0;
                n_halt             = 1'b0;
                n_emitted          = '0;
                n_seen             = 1'b0;
                n_first_open       = 1'b0;
                n_last_close       = 1'b0;
                n_depth            = '0;
                n_depth_err        = 1'b0;
                do_load            = load_ok;
                o_pop              = load_ok;
            end
        end else if (i_head_valid) begin
            if (!cls.ws) begin
                if (!r_seen) begin
                    n_seen       = 1'b1;
                    n_first_open = cls.open;
                end
                n_last_close = cls.close;
                if (cls.open) begin
                    if (r_depth == '1) begin
                        n_depth_err = 1'b1;
                    end else begin
                        n_depth = r_depth + 1'b1;
                    end
                end else if (cls.close) begin
                    if (r_depth == '0) begin
                        n_depth_err = 1'b1;
                    end else begin
                        n_depth = r_depth - 1'b1;
                    end
                end
            end

            if (!r_halt) begin
                if (cls.comma) begin
                    if (r_phase == PH_SIGN) begin
                        n_halt = 1'b1;
                    end else if (has_token) begin
                        need_out  = 1'b1;
                        n_emitted = emitted_inc;
                    end
                    n_phase = PH_LEAD;
                    n_neg   = 1'b0;
                    n_mag   = '0;
                end else begin
                    case (r_phase)
                        PH_SIGN: begin
                            if (cls.digit) begin
                                n_mag   = mag_acc;
                                n_phase = PH_DIGITS;
                            end else begin
                                n_halt  = 1'b1;
                                n_phase = PH_LEAD;
                                n_neg   = 1'b0;
                                n_mag   = '0;
                            end
                        end
                        PH_DIGITS: begin
                            if (cls.digit) begin
                                n_mag = mag_acc;
                            end else if (cls.ws || cls.close) begin
                                n_phase = PH_TAIL;
                            end else begin
                                n_halt  = 1'b1;
                                n_phase = PH_LEAD;
                                n_neg   = 1'b0;
                                n_mag   = '0;
                            end
                        end
                        PH_TAIL: begin
                            if (!(cls.ws || cls.close)) begin
                                n_halt  = 1'b1;
                                n_phase = PH_LEAD;
                                n_neg   = 1'b0;
                                n_mag   = '0;
                            end
                        end
                        default: begin
                            if (cls.ws || cls.open) begin
                                n_phase = PH_LEAD;
                            end else if (cls.sign) begin
                                n_neg   = cls.minus;
                                n_mag   = '0;
                                n_phase = PH_SIGN;
                            end else if (cls.digit) begin
                                n_neg   = 1'b0;
                                n_mag   = {{(VALUE_BITS-4){1'b0}}, cls.dval};
                                n_phase = PH_DIGITS;
                            end else begin
                                n_halt  = 1'b1;
                                n_phase = PH_LEAD;
                                n_neg   = 1'b0;
                                n_mag   = '0;
                            end
                        end
                    endcase
                end
            end

            go      = !need_out || load_ok;
            o_pop   = go;
            do_load = need_out && load_ok;
        end

        if (!go) begin
            n_phase      = r_phase;
            n_neg        = r_neg;
            n_mag        = r_mag;
            n_halt       = r_halt;
            n_emitted    = r_emitted;
            n_seen       = r_seen;
            n_first_open = r_first_open;
            n_last_close = r_last_close;
            n_depth      = r_depth;
            n_depth_err  = r_depth_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LEAD;
            r_neg        <= 1'b0;
            r_mag        <= '0;
            r_halt       <= 1'b0;
            r_emitted    <= '0;
            r_seen       <= 1'b0;
            r_first_open <= 1'b0;
            r_last_close <= 1'b0;
            r_depth      <= '0;
            r_depth_err  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_neg        <= n_neg;
            r_mag        <= n_mag;
            r_halt       <= n_halt;
            r_emitted    <= n_emitted;
            r_seen       <= n_seen;
            r_first_open <= n_first_open;
            r_last_close <= n_last_close;
            r_depth      <= n_depth;
            r_depth_err  <= n_depth_err;
            if (do_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (do_load) begin
            r_out <= n_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    a_sum_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_SUM) |-> r_out.final_res)
        else $error("summary transaction without final flag");

    a_num_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_NUM) |-> (!r_out.halted && !r_out.format_valid))
        else $error("number transaction carries summary flags");

    a_sum_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_load && n_res.kind == KIND_SUM) |=> (r_emitted == '0 && !r_halt
                                                  && r_depth == '0 && r_phase == PH_LEAD))
        else $error("parse state not cleared after end of text");

    a_halt_no_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halt && do_load) |-> (n_res.kind == KIND_SUM))
        else $error("number emitted while halted");

endmodule

FILE: src/bracketed_int_list_parser_top.sv
// Top level of the bracketed integer list parser.
// Usage: feed text one byte per input transaction (op = byte, ch = the byte),
// then one transaction with op = end. Each comma that closes a valid token
// yields a number result; the end transaction yields the pending number, if
// any, and then a summary with the count, halted flag and format flag. The
// parser then starts afresh for the next text.
// Input channel: i_valid / o_stall / i_item. Output channel: o_valid /
// i_stall / o_item. Each side stalls independently through a four-entry
// queue between the classifying front end and the executor.
// Path: a byte enters the queue at acceptance; the executor takes it from the
// queue head, and its result is registered in the output register for o_item.
// Throughput: one byte per cycle while neither side stalls. An end transaction
// that closes a pending number yields two results, the number first and then
// the summary, because the single output register takes one result per cycle.
// Reset (synchronous, i_rst_n low) empties the queue, drops any waiting
// result and returns the parse state to the start of a text.
// While i_stall is high the result held on o_item stays; the executor keeps
// consuming bytes that yield no result, and the queue fills until o_stall.
module bracketed_int_list_parser_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  bilp_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output bilp_pkg::t_out_item o_item
);
    import bilp_pkg::*;

    logic push, pop, full, nempty;
    t_cls wcls, head;

    bilp_front u_front (
        .i_valid (i_valid),
        .i_item  (i_item),
        .i_full  (full),
        .o_stall (o_stall),
        .o_push  (push),
        .o_cls   (wcls)
    );

    bilp_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wdata  (wcls),
        .i_pop    (pop),
        .o_full   (full),
        .o_nempty (nempty),
        .o_rdata  (head)
    );

    bilp_exec u_exec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (nempty),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_item       (o_item)
    );

endmodule

FILE: dv/bracketed_int_list_parser_top_tb.sv
// Self-checking testbench for the bracketed integer list parser: directed texts and random lists.
module bracketed_int_list_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bilp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned RANDOM_ITEMS = 1540;
    localparam logic [63:0] MAG_LIMIT = 64'd1 << (VALUE_BITS - 1);
    localparam logic [DEPTH_BITS-1:0] NEST_MAX = '1;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam logic [7:0] PUNCT [12] = '{CH_OPEN, CH_CLOSE, CH_COMMA, CH_PLUS, CH_MINUS,
        CH_ZERO, CH_NINE, CH_SPACE, CH_TAB, CH_LF, 8'h61, 8'h00};

    typedef enum logic [1:0] {TK_LEAD, TK_SIGN, TK_DIGITS, TK_TAIL} t_tok_phase;

    typedef struct {
        t_in_item    item;
        int unsigned gap;
    } t_feed;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_item;

    bracketed_int_list_parser_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    t_feed       text_feed [$];
    t_out_item   want_results [$];
    int unsigned n_fail = 0;
    int unsigned n_cycles = 0;
    int unsigned idle_cnt = 0;
    int unsigned stall_left = 0;
    bit          quiet = 1'b0;
    bit          calm = 1'b0;

    // Parser state as predicted
    t_tok_phase            tok_phase = TK_LEAD;
    bit                    tok_neg = 1'b0;
    logic [63:0]           tok_mag = '0;
    bit                    halted_q = 1'b0;
    logic [TOTAL_BITS-1:0] n_emitted = '0;
    bit                    seen_ns = 1'b0;
    bit                    first_open = 1'b0;
    bit                    last_close = 1'b0;
    bit                    depth_bad = 1'b0;
    logic [DEPTH_BITS-1:0] nest = '0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit is_space(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void clear_token();
        tok_phase = TK_LEAD;
        tok_neg = 1'b0;
        tok_mag = '0;
    endfunction

    function automatic void clear_text();
        clear_token();
        halted_q = 1'b0;
        n_emitted = '0;
        seen_ns = 1'b0;
        first_open = 1'b0;
        last_close = 1'b0;
        depth_bad = 1'b0;
        nest = '0;
    endfunction

    function automatic void halt_parse();
        halted_q = 1'b1;
        clear_token();
    endfunction

    function automatic void add_digit(logic [7:0] c);
        logic [63:0] d;
        d = c - CH_ZERO;
        if (tok_mag >= MAG_LIMIT || tok_mag > (MAG_LIMIT - d) / 10)
            tok_mag = MAG_LIMIT;
        else
            tok_mag = tok_mag * 10 + d;
    endfunction

    function automatic void push_number(bit fin);
        logic [63:0] v;
        t_out_item   r;
        if (tok_neg)
            v = 64'd0 - (tok_mag > MAG_LIMIT ? MAG_LIMIT : tok_mag);
        else
            v = tok_mag > MAG_LIMIT - 1 ? MAG_LIMIT - 1 : tok_mag;
        if (n_emitted != TOTAL_MAX)
            n_emitted++;
        r.kind = KIND_NUM;
        r.number = v[VALUE_BITS-1:0];
        r.total = n_emitted;
        r.format_valid = 1'b0;
        r.halted = halted_q;
        r.final_res = fin;
        want_results.push_back(r);
    endfunction

    function automatic void close_token(bit fin);
        if (tok_phase == TK_SIGN) begin
            halt_parse();
            return;
        end
        if (tok_phase == TK_DIGITS || tok_phase == TK_TAIL)
            push_number(fin);
        clear_token();
    endfunction

    // Works out the results one accepted transaction causes
    function automatic void parse_step(t_in_item it);
        logic [7:0] c;
        t_out_item  r;
        c = it.ch;
        if (it.op == OP_END) begin
            if (!halted_q)
                close_token(1'b0);
            r.kind = KIND_SUM;
            r.number = '0;
            r.total = n_emitted;
            r.format_valid = seen_ns && first_open && last_close && !depth_bad && nest == 0;
            r.halted = halted_q;
            r.final_res = 1'b1;
            want_results.push_back(r);
            clear_text();
            return;
        end
        if (!is_space(c)) begin
            if (!seen_ns) begin
                seen_ns = 1'b1;
                first_open = (c == CH_OPEN);
            end
            last_close = (c == CH_CLOSE);
            if (c == CH_OPEN) begin
                if (nest == NEST_MAX)
                    depth_bad = 1'b1;
                else
                    nest++;
            end else if (c == CH_CLOSE) begin
                if (nest == 0)
                    depth_bad = 1'b1;
                else
                    nest--;
            end
        end
        if (halted_q)
            return;
        if (c == CH_COMMA) begin
            close_token(1'b1);
            return;
        end
        case (tok_phase)
            TK_SIGN: begin
                if (is_digit(c)) begin
                    add_digit(c);
                    tok_phase = TK_DIGITS;
                end else begin
                    halt_parse();
                end
            end
            TK_DIGITS: begin
                if (is_digit(c))
                    add_digit(c);
                else if (is_space(c) || c == CH_CLOSE)
                    tok_phase = TK_TAIL;
                else
                    halt_parse();
            end
            TK_TAIL: begin
                if (!(is_space(c) || c == CH_CLOSE))
                    halt_parse();
            end
            default: begin
                tok_phase = TK_LEAD;
                if (is_space(c) || c == CH_OPEN) begin
                    // still skipping
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    tok_neg = (c == CH_MINUS);
                    tok_mag = '0;
                    tok_phase = TK_SIGN;
                end else if (is_digit(c)) begin
                    tok_neg = 1'b0;
                    tok_mag = '0;
                    add_digit(c);
                    tok_phase = TK_DIGITS;
                end else begin
                    halt_parse();
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        n_fail++;
        if (n_fail <= 50)
            $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    // Stimulus helpers
    task automatic feed_byte(logic [7:0] c);
        t_feed f;
        if ($urandom_range(0, 49) == 0)
            quiet = !quiet;
        f.item.op = OP_BYTE;
        f.item.ch = c;
        f.gap = quiet ? 0 : $urandom_range(0, 4);
        text_feed.push_back(f);
    endtask

    task automatic feed_end();
        t_feed f;
        f.item.op = OP_END;
        f.item.ch = 8'($urandom_range(0, 255));
        f.gap = quiet ? 0 : $urandom_range(0, 4);
        text_feed.push_back(f);
    endtask

    task automatic feed_text(string s);
        for (int i = 0; i < s.len(); i++)
            feed_byte(s[i]);
    endtask

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 5))
            0: return CH_TAB;
            1: return CH_LF;
            2: return CH_VT;
            3: return CH_FF;
            4: return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] pick_any();
        if ($urandom_range(0, 1) == 0)
            return PUNCT[$urandom_range(0, 11)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic feed_spaces();
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 2)) feed_byte(pick_space());
    endtask

    task automatic feed_token();
        int unsigned s;
        int unsigned ndig;
        s = $urandom_range(0, 5);
        if (s == 0)
            feed_byte(CH_MINUS);
        else if (s == 1)
            feed_byte(CH_PLUS);
        if ($urandom_range(0, 19) == 0) begin
            // sign with no digit
            if (s > 1)
                feed_byte(CH_MINUS);
            return;
        end
        ndig = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
        repeat (ndig) feed_byte(8'(CH_ZERO + $urandom_range(0, 9)));
    endtask

    task automatic feed_list(bit broken);
        int ntok;
        int bad_at;
        ntok = $urandom_range(0, 6);
        bad_at = broken ? $urandom_range(0, ntok) : -1;
        feed_spaces();
        if ($urandom_range(0, 9) != 0)
            feed_byte(CH_OPEN);
        for (int i = 0; i < ntok; i++) begin
            feed_spaces();
            if (i == bad_at)
                feed_byte(pick_any());
            if ($urandom_range(0, 7) == 0)
                feed_byte(CH_OPEN);
            if ($urandom_range(0, 9) != 0)
                feed_token();
            feed_spaces();
            if ($urandom_range(0, 7) == 0)
                feed_byte(CH_CLOSE);
            if (i != ntok - 1)
                feed_byte(CH_COMMA);
        end
        // a list may be cut short before its closing bracket; a broken list with no bad byte in its tokens always is
        if (bad_at != ntok && $urandom_range(0, 9) != 0)
            feed_byte(CH_CLOSE);
        feed_spaces();
        feed_end();
    endtask

    // Input driver
    always @(posedge i_clk) begin : drive
        t_feed nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_item <= '0;
            idle_cnt = 0;
        end else begin
            if (i_valid && !o_stall)
                parse_step(i_item);
            if (i_valid && o_stall) begin
                // held until taken
            end else if (text_feed.size() == 0) begin
                i_valid <= 1'b0;
            end else if (text_feed[0].gap > idle_cnt) begin
                i_valid <= 1'b0;
                idle_cnt++;
            end else begin
                nxt = text_feed.pop_front();
                idle_cnt = 0;
                i_item <= nxt.item;
                i_valid <= 1'b1;
            end
        end
    end

    // Result monitor and output stall
    always @(posedge i_clk) begin : watch
        t_out_item exp_r;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (want_results.size() == 0) begin
                    report_mismatch("unexpected result", o_item, '0);
                end else begin
                    exp_r = want_results.pop_front();
                    if (o_item.kind !== exp_r.kind)
                        report_mismatch("kind", o_item.kind, exp_r.kind);
                    if (o_item.number !== exp_r.number)
                        report_mismatch("number", o_item.number, exp_r.number);
                    if (o_item.total !== exp_r.total)
                        report_mismatch("total", o_item.total, exp_r.total);
                    if (o_item.format_valid !== exp_r.format_valid)
                        report_mismatch("format_valid", o_item.format_valid,
                                        exp_r.format_valid);
                    if (o_item.halted !== exp_r.halted)
                        report_mismatch("halted", o_item.halted, exp_r.halted);
                    if (o_item.final_res !== exp_r.final_res)
                        report_mismatch("final_res", o_item.final_res, exp_r.final_res);
                end
                if ($urandom_range(0, 39) == 0)
                    calm = !calm;
                stall_left = calm ? 0 : $urandom_range(0, 4);
            end
            if (stall_left != 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned rnd_start;
        int unsigned k;

        // empty text, then simple and saturating lists
        feed_end();
        feed_text("[1, -2, +3]");
        feed_end();
        feed_text("[2147483647,2147483648,-2147483648,-2147483649,99999999999]");
        feed_end();
        // sign-only tokens: before a bracket, at a comma, at end of text
        feed_text("[-]");
        feed_end();
        feed_text("[+,5]");
        feed_end();
        feed_text("[7, -");
        feed_end();
        // lone closing bracket as a token, depth going negative, unbalanced
        feed_text("[], 1]");
        feed_end();
        feed_text("]1[");
        feed_end();
        feed_text("[[1]");
        feed_end();
        feed_text("[1 2]");
        feed_end();
        feed_text("[1x]");
        feed_end();
        feed_text("[,,4 ,]");
        feed_end();
        feed_text("5]");
        feed_end();
        feed_text("[0005");
        feed_end();
        // every whitespace byte
        feed_byte(CH_OPEN);
        feed_byte(CH_TAB);
        feed_byte(8'h31);
        feed_byte(CH_CR);
        feed_byte(CH_COMMA);
        feed_byte(CH_VT);
        feed_byte(8'h32);
        feed_byte(CH_FF);
        feed_byte(CH_LF);
        feed_byte(CH_CLOSE);
        feed_byte(CH_SPACE);
        feed_end();
        // NUL and top-bit bytes are ordinary characters
        feed_byte(CH_OPEN);
        feed_byte(8'h00);
        feed_end();
        feed_text("[8");
        feed_byte(8'hFF);
        feed_end();

        rnd_start = text_feed.size();
        while (text_feed.size() - rnd_start < RANDOM_ITEMS) begin
            k = $urandom_range(0, 9);
            if (k < 6) begin
                feed_list(1'b0);
            end else if (k < 8) begin
                feed_list(1'b1);
            end else begin
                repeat ($urandom_range(1, 20)) feed_byte(pick_any());
                feed_end();
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (!(text_feed.size() == 0 && !i_valid && want_results.size() == 0));
        repeat (20) @(posedge i_clk);

        if (n_fail == 0 && want_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
